FILE: sv/constant_velocity_reflect_predictor_macros.svh
// assertion macros shared by the predictor checker
`ifndef CONSTANT_VELOCITY_REFLECT_PREDICTOR_MACROS_SVH
`define CONSTANT_VELOCITY_REFLECT_PREDICTOR_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define CVRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define CVRP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: sv/cvrp_pkg.sv
// shared types and constants of the reflecting obstacle predictor
`timescale 1ns / 1ps

package cvrp_pkg;

   // field widths
   localparam int POS_W   = 32;
   localparam int HALF_W  = 31;
   localparam int HOR_W   = 6;
   localparam int TIME_W  = 16;
   localparam int GAIN_W  = 16;

   // fixed point shifts of gain and time
   localparam int GAIN_SHIFT = 8;
   localparam int TIME_SHIFT = 16;

   // accumulated step time k*step_time
   localparam int T_W    = TIME_W + HOR_W;
   // shared multiplier operands and product
   localparam int MUL_A_W = POS_W + 1;
   localparam int MUL_B_W = T_W + 1;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   // widened position and offset
   localparam int WIDE_W  = 40;
   localparam int OFF_W   = WIDE_W + 1;

   // divider sizes
   localparam int DIVD_W     = WIDE_W;
   localparam int DIVS_W     = POS_W;
   localparam int DIV_STEPS  = DIVD_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   // register port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [1:0] REG_HORIZON = 2'd0;
   localparam logic [1:0] REG_STEP    = 2'd1;
   localparam logic [1:0] REG_GAIN    = 2'd2;

   // register reset values
   localparam logic [HOR_W-1:0]  HORIZON_RESET = 6'd10;
   localparam logic [TIME_W-1:0] STEP_RESET    = 16'd6554;
   localparam logic [GAIN_W-1:0] GAIN_RESET    = 16'd256;

   // saturation limits
   localparam logic [HALF_W-1:0] EXTENT_MAX = {HALF_W{1'b1}};
   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

   typedef struct packed {
      logic [HOR_W-1:0]  horizon;
      logic [TIME_W-1:0] step_time;
      logic [GAIN_W-1:0] expand_gain;
   } cfg_type;

   typedef struct packed {
      logic done;
      logic q_odd;
   } div_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_POS,
      ST_OFF,
      ST_DIV,
      ST_FIX,
      ST_EMIT
   } state_type;

endpackage

FILE: sv/cvrp_csr.sv
// configuration registers behind the register port
`timescale 1ns / 1ps

module cvrp_csr
   import cvrp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [HOR_W-1:0]  horizon_ff, horizon_in;
   logic [TIME_W-1:0] step_ff, step_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign reg_idx = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en   = csr_psel & csr_penable & csr_pwrite;

   // write decode
   always_comb begin
      horizon_in = horizon_ff;
      step_in    = step_ff;
      gain_in    = gain_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_HORIZON: horizon_in = csr_pwdata[HOR_W-1:0];
            REG_STEP:    step_in    = csr_pwdata[TIME_W-1:0];
            REG_GAIN:    gain_in    = csr_pwdata[GAIN_W-1:0];
            default:     ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         horizon_ff <= HORIZON_RESET;
         step_ff    <= STEP_RESET;
         gain_ff    <= GAIN_RESET;
      end else begin
         horizon_ff <= horizon_in;
         step_ff    <= step_in;
         gain_ff    <= gain_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_HORIZON: csr_prdata = CSR_DATA_W'(horizon_ff);
         REG_STEP:    csr_prdata = CSR_DATA_W'(step_ff);
         REG_GAIN:    csr_prdata = CSR_DATA_W'(gain_ff);
         default:     csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   assign cfg.horizon     = horizon_ff;
   assign cfg.step_time   = step_ff;
   assign cfg.expand_gain = gain_ff;

endmodule

FILE: sv/cvrp_div.sv
// restoring divider, one quotient bit per cycle, remainder and quotient parity
`timescale 1ns / 1ps

module cvrp_div
   import cvrp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DIVS_W-1:0] divisor,
   output div_status_type    status,
   output logic [DIVS_W-1:0] remainder
);

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIVD_W-1:0]    dvd_ff;
   logic [DIVS_W-1:0]    dvs_ff;
   logic [DIVS_W-1:0]    rem_ff;
   logic                 q_odd_ff;
   logic [DIVS_W:0]      partial;
   logic [DIVS_W+1:0]    diff;
   logic                 fits;

   // trial subtract of the shifted partial remainder
   always_comb begin
      partial = {rem_ff, dvd_ff[DIVD_W-1]};
      diff    = {1'b0, partial} - {2'b00, dvs_ff};
      fits    = ~diff[DIVS_W+1];
   end

   // step control
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = busy_ff && (cnt_ff == DIV_LAST);
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // shift and subtract
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff   <= {dvd_ff[DIVD_W-2:0], 1'b0};
         rem_ff   <= fits ? diff[DIVS_W-1:0] : partial[DIVS_W-1:0];
         q_odd_ff <= fits;
      end
   end

   assign status.done  = done_ff;
   assign status.q_odd = q_odd_ff;
   assign remainder    = rem_ff;

endmodule

FILE: sv/constant_velocity_reflect_predictor.sv
// top level: per-axis constant velocity predictor with reflecting bounds
// frame 0: multiply, sum and output steps after the request is taken
// unbounded frame: multiply, sum, saturate and output steps, plus output stall
// folded frame: adds offset, divide and fix steps; 40-step restoring divider folds
// a new request is taken only in idle, after the last frame of the previous one
// synchronous active-high reset returns to idle and loads register defaults
`timescale 1ns / 1ps

module constant_velocity_reflect_predictor
   import cvrp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [POS_W-1:0]  req_center_pos,
   input  logic signed [POS_W-1:0]  req_axis_velocity,
   input  logic [HALF_W-1:0]        req_half_size,
   input  logic signed [POS_W-1:0]  req_bound_low,
   input  logic signed [POS_W-1:0]  req_bound_high,
   input  logic                     req_bounds_enabled,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [HOR_W-1:0]         rsp_frame_index,
   output logic signed [POS_W-1:0]  rsp_position,
   output logic [HALF_W-1:0]        rsp_extent,
   output logic                     rsp_last_frame,
   // register port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [CSR_DATA_W-1:0]    csr_pwdata,
   output logic [CSR_DATA_W-1:0]    csr_prdata,
   output logic                     csr_pready
);

   cfg_type          cfg;
   div_status_type   div_status;
   logic [DIVS_W-1:0] div_rem;
   logic             div_start;

   state_type        state_ff, state_in;

   // request fields held for the whole request
   logic signed [POS_W-1:0] center_ff;
   logic signed [POS_W-1:0] vel_ff;
   logic [POS_W-1:0]        vel_abs_ff;
   logic [HALF_W-1:0]       half_ff;
   logic signed [POS_W-1:0] lo_ff;
   logic signed [POS_W-1:0] hi_ff;
   logic [DIVS_W-1:0]       range_ff;
   logic                    fold_ff;

   // frame sequencing
   logic [HOR_W-1:0]        k_ff;
   logic [T_W-1:0]          t_ff;

   // datapath
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [WIDE_W-1:0] pos_ff;
   logic signed [OFF_W-1:0]  offset_ff;
   logic [DIVS_W-1:0]        r_ff;
   logic                     odd_ff;
   logic signed [POS_W-1:0]  out_pos_ff;
   logic [HALF_W-1:0]        out_ext_ff;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic [WIDE_W:0]           ext_sum;
   logic signed [WIDE_W-1:0]  pos_sum;
   logic signed [OFF_W-1:0]   offset_sum;
   logic [OFF_W-1:0]          offset_mag;
   logic                      rem_nz;
   logic                      last;
   logic [POS_W:0]            range_full;

   cvrp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cvrp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (offset_mag[DIVD_W-1:0]),
      .divisor   (range_ff),
      .status    (div_status),
      .remainder (div_rem)
   );

   assign last = (k_ff == cfg.horizon);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_MUL;
         ST_MUL:  state_in = ST_SUM;
         ST_SUM:  state_in = (k_ff == '0) ? ST_EMIT : ST_POS;
         ST_POS:  state_in = fold_ff ? ST_OFF : ST_EMIT;
         ST_OFF:  state_in = ST_DIV;
         ST_DIV:  if (div_status.done) state_in = ST_FIX;
         ST_FIX:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (!rsp_stall) begin
               state_in = last ? ST_IDLE : ST_MUL;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // handshake and divider control
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_OFF:  div_start = 1'b1;
         ST_EMIT: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   // shared multiplier operands: |v|*gain for frame 0, v*k*dt afterwards
   always_comb begin
      if (k_ff == '0) begin
         mul_a = $signed({1'b0, vel_abs_ff});
         mul_b = $signed(MUL_B_W'(cfg.expand_gain));
      end else begin
         mul_a = MUL_A_W'(vel_ff);
         mul_b = $signed({1'b0, t_ff});
      end
   end

   // adders of the sum, offset and fold steps
   always_comb begin
      ext_sum    = (WIDE_W+1)'(half_ff) + (WIDE_W+1)'(prod_ff[GAIN_SHIFT +: WIDE_W]);
      pos_sum    = WIDE_W'(center_ff) + $signed(prod_ff[TIME_SHIFT +: WIDE_W]);
      offset_sum = OFF_W'(pos_ff) - OFF_W'(lo_ff);
      offset_mag = offset_ff[OFF_W-1] ? OFF_W'(~offset_ff + 1'b1) : offset_ff;
      rem_nz     = (div_rem != '0);
      range_full = (POS_W+1)'(req_bound_high) - (POS_W+1)'(req_bound_low);
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               center_ff  <= req_center_pos;
               vel_ff     <= req_axis_velocity;
               vel_abs_ff <= req_axis_velocity[POS_W-1] ?
                             POS_W'(~req_axis_velocity + 1'b1) : req_axis_velocity;
               half_ff    <= req_half_size;
               lo_ff      <= req_bound_low;
               hi_ff      <= req_bound_high;
               range_ff   <= range_full[DIVS_W-1:0];
               fold_ff    <= req_bounds_enabled && (req_bound_low < req_bound_high);
               k_ff       <= '0;
               t_ff       <= '0;
            end
         end
         ST_MUL: prod_ff <= mul_a * mul_b;
         ST_SUM: begin
            if (k_ff == '0) begin
               // frame 0: current center, size grown by velocity
               out_pos_ff <= center_ff;
               out_ext_ff <= (ext_sum > (WIDE_W+1)'(EXTENT_MAX)) ?
                             EXTENT_MAX : ext_sum[HALF_W-1:0];
            end else begin
               pos_ff     <= pos_sum;
               out_ext_ff <= half_ff;
            end
         end
         ST_POS: begin
            offset_ff <= offset_sum;
            // saturate when no fold applies
            if (pos_ff > WIDE_W'(POS_MAX)) begin
               out_pos_ff <= POS_MAX;
            end else if (pos_ff < WIDE_W'(POS_MIN)) begin
               out_pos_ff <= POS_MIN;
            end else begin
               out_pos_ff <= pos_ff[POS_W-1:0];
            end
         end
         ST_DIV: begin
            // floor division: negative offset with remainder drops one period
            if (div_status.done) begin
               if (offset_ff[OFF_W-1] && rem_nz) begin
                  r_ff   <= range_ff - div_rem;
                  odd_ff <= ~div_status.q_odd;
               end else begin
                  r_ff   <= div_rem;
                  odd_ff <= div_status.q_odd;
               end
            end
         end
         ST_FIX: begin
            // even cycle counts up from low, odd counts down from high
            out_pos_ff <= odd_ff ? $signed(hi_ff - r_ff) : $signed(lo_ff + r_ff);
         end
         ST_EMIT: begin
            if (!rsp_stall && !last) begin
               k_ff <= k_ff + 1'b1;
               t_ff <= t_ff + T_W'(cfg.step_time);
            end
         end
         default: ;
      endcase
   end

   assign rsp_frame_index = k_ff;
   assign rsp_position    = out_pos_ff;
   assign rsp_extent      = out_ext_ff;
   assign rsp_last_frame  = last;

endmodule

FILE: sv/cvrp_checker.sv
// port-level checks of the predictor sequencing, bound to the top level
`timescale 1ns / 1ps
`include "constant_velocity_reflect_predictor_macros.svh"

module cvrp_checker
   import cvrp_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic                    rsp_last_frame,
   input logic [HOR_W-1:0]        rsp_frame_index,
   input logic signed [POS_W-1:0] rsp_position
);

   logic req_take;
   logic rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   // a taken request makes the block busy with no result yet
   `CVRP_ASSERT_NEXT(a_req_busy, clock, reset, req_take, req_stall && !rsp_valid, "busy after request")
   // no new request is taken while a result is shown
   `CVRP_ASSERT_SAME(a_rsp_busy, clock, reset, rsp_valid, req_stall, "request open during result")
   // a frame that is not the last leads to more work, not a repeat
   `CVRP_ASSERT_NEXT(a_mid_frame, clock, reset, rsp_take && !rsp_last_frame, req_stall && !rsp_valid, "frame repeated")
   // the last frame frees the block
   `CVRP_ASSERT_NEXT(a_last_frame, clock, reset, rsp_take && rsp_last_frame, !req_stall && !rsp_valid, "not idle after last frame")
   // a stalled result holds
   `CVRP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_position) && $stable(rsp_frame_index), "stalled result changed")

endmodule

bind constant_velocity_reflect_predictor cvrp_checker u_cvrp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_last_frame  (rsp_last_frame),
   .rsp_frame_index (rsp_frame_index),
   .rsp_position    (rsp_position)
);

FILE: bench/testbench.sv
// self-checking bench for the reflecting constant velocity obstacle predictor
`timescale 1ns / 1ps

module testbench;
   import cvrp_pkg::*;

   // run limit in clock cycles, far above the slowest legal run
   localparam int CYCLE_LIMIT = 5000000;
   // register index that decodes to nothing
   localparam logic [1:0] REG_UNUSED = 2'd3;
   // cycles to wait after the last frame before touching registers
   localparam int SETTLE_CYCLES = 8;
   // slots in the expected frame ring, above the frames of one request
   localparam int RING_DEPTH = 128;

   // one predicted result frame
   typedef struct packed {
      logic [HOR_W-1:0]         frame;
      logic signed [POS_W-1:0]  position;
      logic [HALF_W-1:0]        extent;
      logic                     last;
   } frame_rec_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [POS_W-1:0]  req_center_pos = '0;
   logic signed [POS_W-1:0]  req_axis_velocity = '0;
   logic [HALF_W-1:0]        req_half_size = '0;
   logic signed [POS_W-1:0]  req_bound_low = '0;
   logic signed [POS_W-1:0]  req_bound_high = '0;
   logic                     req_bounds_enabled = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [HOR_W-1:0]         rsp_frame_index;
   logic signed [POS_W-1:0]  rsp_position;
   logic [HALF_W-1:0]        rsp_extent;
   logic                     rsp_last_frame;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]    csr_paddr = '0;
   logic [CSR_DATA_W-1:0]    csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]    csr_prdata;
   logic                     csr_pready;

   // register copies used by the frame predictor
   logic [HOR_W-1:0]  model_horizon = HORIZON_RESET;
   logic [TIME_W-1:0] model_step = STEP_RESET;
   logic [GAIN_W-1:0] model_gain = GAIN_RESET;

   // expected frames in arrival order
   frame_rec_type frame_ring [RING_DEPTH];
   int ring_wr = 0;
   int ring_rd = 0;
   int error_count = 0;
   // no random idling on either side while set, but hold-offs still stall
   bit calm = 1'b0;
   // receiver hold-off, counted down by the receiver
   int hold_cycles = 0;

   constant_velocity_reflect_predictor DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_center_pos     (req_center_pos),
      .req_axis_velocity  (req_axis_velocity),
      .req_half_size      (req_half_size),
      .req_bound_low      (req_bound_low),
      .req_bound_high     (req_bound_high),
      .req_bounds_enabled (req_bounds_enabled),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_frame_index    (rsp_frame_index),
      .rsp_position       (rsp_position),
      .rsp_extent         (rsp_extent),
      .rsp_last_frame     (rsp_last_frame),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("constant_velocity_reflect_predictor test failed");
      $finish;
   end

   // all frames of one request under the current register copies
   function automatic void predict_frames(input logic signed [POS_W-1:0] center,
                                          input logic signed [POS_W-1:0] vel,
                                          input logic [HALF_W-1:0] half,
                                          input logic signed [POS_W-1:0] lo,
                                          input logic signed [POS_W-1:0] hi,
                                          input logic enabled);
      longint c, v, h, l, u, speed, grown, t, p, span, off, q, r, res;
      bit fold;
      int k;
      frame_rec_type f;
      c = center;
      v = vel;
      h = longint'(half);
      l = lo;
      u = hi;
      fold = enabled && (l < u);
      // frame 0: current center, size grown by speed times gain
      speed = (v < 0) ? -v : v;
      grown = h + ((speed * longint'(model_gain)) >>> GAIN_SHIFT);
      if (grown > 64'sd2147483647) grown = 64'sd2147483647;
      f.frame = '0;
      f.position = center;
      f.extent = grown[HALF_W-1:0];
      f.last = (model_horizon == 0);
      frame_ring[ring_wr % RING_DEPTH] = f;
      ring_wr++;
      // later frames: floor of velocity times elapsed time, then fold or clamp
      for (k = 1; k <= model_horizon; k++) begin
         t = k * longint'(model_step);
         p = c + ((v * t) >>> TIME_SHIFT);
         if (fold) begin
            span = u - l;
            off = p - l;
            q = off / span;
            if ((off % span) != 0 && off < 0) q = q - 1;
            r = off - q * span;
            res = q[0] ? (u - r) : (l + r);
         end else if (p > 64'sd2147483647) begin
            res = 64'sd2147483647;
         end else if (p < -64'sd2147483648) begin
            res = -64'sd2147483648;
         end else begin
            res = p;
         end
         f.frame = k[HOR_W-1:0];
         f.position = res[POS_W-1:0];
         f.extent = half;
         f.last = (k == model_horizon);
         frame_ring[ring_wr % RING_DEPTH] = f;
         ring_wr++;
      end
   endfunction

   // predict on accepted requests, check each accepted frame
   always @(posedge clock) begin : frame_monitor
      frame_rec_type want;
      if (!reset && req_valid && !req_stall)
         predict_frames(req_center_pos, req_axis_velocity, req_half_size,
                        req_bound_low, req_bound_high, req_bounds_enabled);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (ring_wr == ring_rd) begin
            $error("frame %0d arrived with no request pending", rsp_frame_index);
            error_count++;
         end else begin
            want = frame_ring[ring_rd % RING_DEPTH];
            ring_rd++;
            if (rsp_frame_index !== want.frame) begin
               $error("frame_index mismatch: expected %0d, actual %0d",
                      want.frame, rsp_frame_index);
               error_count++;
            end
            if (rsp_position !== want.position) begin
               $error("position mismatch: expected %0d, actual %0d",
                      want.position, rsp_position);
               error_count++;
            end
            if (rsp_extent !== want.extent) begin
               $error("extent mismatch: expected %0d, actual %0d", want.extent, rsp_extent);
               error_count++;
            end
            if (rsp_last_frame !== want.last) begin
               $error("last_frame mismatch: expected %0d, actual %0d",
                      want.last, rsp_last_frame);
               error_count++;
            end
         end
      end
   end

   // receiver: random stalls, quiet stretches and long hold-offs
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles = hold_cycles - 1;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 32);
      end
   end

   // offer one request, with an optional gap first, and wait until it is taken
   task automatic send_request(input logic signed [POS_W-1:0] center,
                               input logic signed [POS_W-1:0] vel,
                               input logic [HALF_W-1:0] half,
                               input logic signed [POS_W-1:0] lo,
                               input logic signed [POS_W-1:0] hi,
                               input logic enabled);
      int gap;
      if (!calm && $urandom_range(99) < 32) begin
         gap = ($urandom_range(4) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_center_pos <= center;
      req_axis_velocity <= vel;
      req_half_size <= half;
      req_bound_low <= lo;
      req_bound_high <= hi;
      req_bounds_enabled <= enabled;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop offering and wait until every predicted frame has come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (ring_wr != ring_rd) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write: setup cycle, then access cycle
   task automatic write_register(input logic [1:0] index, input logic [CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         REG_HORIZON: model_horizon = value[HOR_W-1:0];
         REG_STEP:    model_step = value[TIME_W-1:0];
         REG_GAIN:    model_gain = value[GAIN_W-1:0];
         default: ;
      endcase
   endtask

   // random request, mostly with reflecting bounds around the center
   task automatic random_request();
      logic signed [POS_W-1:0] c, v, lo, hi;
      logic [HALF_W-1:0] h;
      logic en;
      int shape, span;
      shape = $urandom_range(9);
      c = $urandom;
      v = $urandom;
      h = $urandom;
      lo = $urandom;
      hi = $urandom;
      en = $urandom_range(1);
      if (shape < 6) begin
         if ($urandom_range(1)) c = $signed($urandom) >>> $urandom_range(8, 24);
         v = $signed($urandom) >>> $urandom_range(0, 20);
         span = (shape < 2) ? $urandom_range(1, 16) : $urandom_range(1, 1 << 22);
         lo = c - $urandom_range(0, span);
         hi = lo + span;
         en = 1'b1;
      end else if (shape == 6) begin
         // empty or inverted bounds
         hi = lo - $urandom_range(0, 5);
         en = 1'b1;
      end else if (shape == 7) begin
         // sound bounds but folding switched off
         v = $signed($urandom) >>> $urandom_range(0, 20);
         lo = c - $urandom_range(0, 1 << 20);
         hi = lo + $urandom_range(1, 1 << 20);
         en = 1'b0;
      end
      send_request(c, v, h, lo, hi, en);
   endtask

   // directed corners under the reset register values
   task automatic test_reset_defaults();
      // all zero
      send_request(0, 0, 0, 0, 0, 1'b0);
      // largest center, speed and size: extent and position clamp high
      send_request(32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff, 0, 0, 1'b0);
      // most negative center and speed: position clamps low
      send_request(-32'sh80000000, -32'sh80000000, 31'h7fffffff, 0, 0, 1'b0);
      // bounce inside a three meter box
      send_request(0, 10 << 16, 1 << 15, -(1 << 16), 2 << 16, 1'b1);
      // start far below the box, heading further down
      send_request(-(3 << 16), -(5 << 16), 100, 0, 1 << 16, 1'b1);
      // equal bounds: no fold
      send_request(1 << 16, 3 << 16, 7, 1 << 16, 1 << 16, 1'b1);
      // inverted bounds: no fold
      send_request(0, 2 << 16, 7, 5 << 16, -(5 << 16), 1'b1);
      // sound bounds with folding off
      send_request(0, 10 << 16, 9, 0, 1 << 16, 1'b0);
      // widest possible bounds
      send_request(32'sh7fff0000, 32'sh7fffffff, 3, -32'sh80000000, 32'sh7fffffff, 1'b1);
      // box one unit wide
      send_request(5, 32'sh00123456, 1, 5, 6, 1'b1);
      // at rest exactly two ranges below low: zero remainder
      send_request(-(4 << 16), 0, 0, 0, 2 << 16, 1'b1);
      // slow negative drift: floor rounding toward minus infinity
      send_request(0, -1, 0, 0, 0, 1'b0);
      settle();
   endtask

   // only frame 0 comes out, flagged as last
   task automatic test_zero_horizon();
      write_register(REG_HORIZON, 32'h0000_0040);
      send_request(12345, -(7 << 16), 31'h0000_ffff, 0, 1 << 16, 1'b1);
      send_request(-32'sh80000000, -32'sh80000000, 31'h7fff0000, 0, 0, 1'b0);
      send_request(32'sh7fffffff, 32'sh40000000, 31'h7fffffff, -5, 5, 1'b1);
      settle();
   endtask

   // register extremes, with junk in the bits above each width
   task automatic test_extreme_registers();
      write_register(REG_HORIZON, 32'hffff_ffff);
      write_register(REG_STEP, 32'hffff_ffff);
      write_register(REG_GAIN, 32'hffff_ffff);
      write_register(REG_UNUSED, 32'h0000_0001);
      send_request(0, 32'sh7fffffff, 31'h7fffffff, -(1 << 20), 1 << 20, 1'b1);
      send_request(32'sh7fffffff, 32'sh7fffffff, 0, 0, 0, 1'b0);
      send_request(-32'sh80000000, -32'sh80000000, 1, 10, 3, 1'b1);
      settle();
      write_register(REG_HORIZON, 32'hffff_ff01);
      write_register(REG_STEP, 32'hffff_0000);
      write_register(REG_GAIN, 32'h5555_0000);
      send_request(777, 32'sh7fffffff, 31'h12345, 0, 100, 1'b1);
      send_request(-777, -32'sh80000000, 31'h7fffffff, 0, 0, 1'b0);
      settle();
   endtask

   // long receiver hold-off while requests keep coming
   task automatic test_output_backpressure();
      write_register(REG_HORIZON, 32'd3);
      write_register(REG_STEP, $urandom);
      write_register(REG_GAIN, $urandom);
      calm = 1'b1;
      hold_cycles = 800;
      repeat (14) random_request();
      calm = 1'b0;
      settle();
   endtask

   // random requests over several random register settings
   task automatic test_random_sweep();
      int phase;
      logic [CSR_DATA_W-1:0] word;
      for (phase = 0; phase < 4; phase++) begin
         word = $urandom;
         word[HOR_W-1:0] = ($urandom_range(3) == 0) ? $urandom_range(8, 24)
                                                     : $urandom_range(0, 6);
         write_register(REG_HORIZON, word);
         write_register(REG_STEP, $urandom);
         write_register(REG_GAIN, $urandom);
         calm = (phase == 2);
         repeat (56) random_request();
         calm = 1'b0;
         settle();
      end
   endtask

   // test sequence
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_zero_horizon();
      test_extreme_registers();
      test_output_backpressure();
      test_random_sweep();
      settle();
      if (error_count == 0)
         $display("constant_velocity_reflect_predictor test passed");
      else
         $display("constant_velocity_reflect_predictor test failed");
      $finish;
   end

endmodule

FILE: files.f
+incdir+sv
sv/cvrp_pkg.sv
sv/cvrp_csr.sv
sv/cvrp_div.sv
sv/constant_velocity_reflect_predictor.sv
sv/cvrp_checker.sv
bench/testbench.sv
